// ----- rtl/core/tsa_pkg.sv -----
// Shared constants, codes and types of the table slot allocator.
package tsa_pkg;

   // Map geometry. SLOTS must be a multiple of WORD_W.
   localparam int SLOTS  = 8192;
   localparam int RUN    = 16;
   localparam int WORD_W = 32;
   localparam int LOG_W  = $clog2(WORD_W);
   localparam int ROWS   = SLOTS / WORD_W;
   localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
   localparam int PREV_W = RUN - 1;
   localparam int POS_W  = LOG_W;

   // Field widths of the request and response words.
   localparam int MODE_W = 2;
   localparam int SLOT_W = 13;
   localparam int ADDR_W = 32;

   // Width of a slot position with headroom for a run end past the map.
   localparam int GW = ((SLOT_W > $clog2(SLOTS)) ? SLOT_W : $clog2(SLOTS)) + 2;

   // Each slot spans 1024 bytes of the table area.
   localparam int SLOT_SHIFT = 10;

   // Register port.
   localparam int PADDR_W = 2;
   localparam int PDATA_W = 32;
   localparam logic [PADDR_W-1:0] REG_TABLE_BASE = 2'd0;
   localparam logic [PDATA_W-1:0] TABLE_BASE_RESET = 32'h0010_0000;

   // Request modes.
   localparam logic [MODE_W-1:0] MODE_ALLOC_ONE = 2'd0;
   localparam logic [MODE_W-1:0] MODE_ALLOC_RUN = 2'd1;
   localparam logic [MODE_W-1:0] MODE_FREE_ONE  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_FREE_RUN  = 2'd3;

   // Response status codes.
   localparam logic STATUS_DONE     = 1'b0;
   localparam logic STATUS_NO_SPACE = 1'b1;

   // Result of scanning one map row.
   typedef struct packed {
      logic             hit;
      logic [POS_W-1:0] pos;
   } scan_res_type;

endpackage

// ----- rtl/core/tsa_intf.sv -----
// Valid/ready channel interfaces for the request and response words.
interface tsa_req_intf;
   logic                          valid;
   logic                          ready;
   logic [tsa_pkg::MODE_W-1:0]    mode;
   logic [tsa_pkg::SLOT_W-1:0]    slot_index;

   modport source (output valid, output mode, output slot_index, input ready);
   modport sink   (input valid, input mode, input slot_index, output ready);
endinterface

interface tsa_rsp_intf;
   logic                          valid;
   logic                          ready;
   logic                          status;
   logic [tsa_pkg::SLOT_W-1:0]    slot_number;
   logic [tsa_pkg::ADDR_W-1:0]    slot_address;

   modport source (output valid, output status, output slot_number, output slot_address,
                   input ready);
   modport sink   (input valid, input status, input slot_number, input slot_address,
                   output ready);
endinterface

// ----- rtl/core/tsa_csr.sv -----
// Register port holding the table base address.
module tsa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tsa_pkg::PADDR_W-1:0]  paddr,
   input  logic [tsa_pkg::PDATA_W-1:0]  pwdata,
   output logic [tsa_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready,
   output logic [tsa_pkg::ADDR_W-1:0]   table_base
);

   logic [tsa_pkg::ADDR_W-1:0] base_ff;
   logic [tsa_pkg::ADDR_W-1:0] base_in;
   logic                       wr_en;

   assign wr_en = psel && penable && pwrite && (paddr == tsa_pkg::REG_TABLE_BASE);

   always_comb begin
      base_in = base_ff;
      if (wr_en) begin
         base_in = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff <= tsa_pkg::TABLE_BASE_RESET;
      end else begin
         base_ff <= base_in;
      end
   end

   assign pready     = 1'b1;
   assign prdata     = (paddr == tsa_pkg::REG_TABLE_BASE) ? base_ff : '0;
   assign table_base = base_ff;

endmodule

// ----- rtl/core/tsa_scan_unit.sv -----
// Shared row scanner: finds the first free slot or the first run end in one map row.
module tsa_scan_unit (
   input  logic [tsa_pkg::WORD_W-1:0] row_bits,
   input  logic [tsa_pkg::PREV_W-1:0] prev_bits,
   input  logic                       single,
   output tsa_pkg::scan_res_type      result,
   output logic [tsa_pkg::PREV_W-1:0] next_prev
);

   localparam int WIN_W = tsa_pkg::WORD_W + tsa_pkg::PREV_W;

   logic [WIN_W-1:0]          window;
   logic [tsa_pkg::WORD_W-1:0] match;

   // The window holds the tail of the rows already scanned below this row.
   assign window    = {row_bits, prev_bits};
   assign next_prev = window[WIN_W-1 -: tsa_pkg::PREV_W];

   always_comb begin
      for (int j = 0; j < tsa_pkg::WORD_W; j++) begin
         if (single) begin
            match[j] = ~row_bits[j];
         end else begin
            match[j] = ~|window[j +: tsa_pkg::RUN];
         end
      end
   end

   always_comb begin
      result.hit = |match;
      result.pos = '0;
      for (int j = tsa_pkg::WORD_W - 1; j >= 0; j--) begin
         if (match[j]) begin
            result.pos = tsa_pkg::POS_W'(j);
         end
      end
   end

endmodule

// ----- rtl/core/table_slot_allocator.sv -----
// Top level of the table slot allocator: map memory, sequencer and response register.
//
// The allocator keeps one used/free bit per table slot in a map memory of 32-bit rows.
// After reset it runs a clearing pass of one row per cycle over all SLOTS/32 rows (256
// at the default size) and takes no request word until the pass is done; register
// writes are taken throughout. A request word is then handled one at a time. Allocation
// scans the map from row zero through a single row scanner, one row per cycle, with the
// row read registered; the scanner carries the tail of earlier rows so that a run may
// straddle rows. Marking or freeing then does a setup step and a read-modify-write of
// each touched row (one row for a single slot, up to two rows for a run of sixteen).
// The response word is held in its own state until taken, and the next request word is
// accepted the cycle after that. The slot address is table_base plus 1024 times the
// slot number, modulo 2 to the 32. A run is only found wholly inside the map, and a
// freed run that reaches past the last slot is clipped at the end of the map.
module table_slot_allocator (
   input  logic                         clock,
   input  logic                         reset,
   tsa_req_intf.sink                    req_if,
   tsa_rsp_intf.source                  rsp_if,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [tsa_pkg::PADDR_W-1:0]  paddr,
   input  logic [tsa_pkg::PDATA_W-1:0]  pwdata,
   output logic [tsa_pkg::PDATA_W-1:0]  prdata,
   output logic                         pready
);

   localparam int W   = tsa_pkg::WORD_W;
   localparam int RW  = tsa_pkg::ROW_W;
   localparam int GW  = tsa_pkg::GW;
   localparam int RGW = GW - tsa_pkg::LOG_W;

   localparam logic [RW:0]    ROWS_CNT  = (RW + 1)'(tsa_pkg::ROWS);
   localparam logic [RW-1:0]  LAST_ROW  = RW'(tsa_pkg::ROWS - 1);
   localparam logic [RGW-1:0] ROWS_WIDE = RGW'(tsa_pkg::ROWS);
   localparam logic [GW-1:0]  RUN_SPAN  = GW'(tsa_pkg::RUN - 1);

   // Sequencer states.
   typedef enum logic [6:0] {
      ST_CLEAR   = 7'b0000001,
      ST_IDLE    = 7'b0000010,
      ST_SCAN    = 7'b0000100,
      ST_SETUP   = 7'b0001000,
      ST_MARK_RD = 7'b0010000,
      ST_MARK_WR = 7'b0100000,
      ST_RESP    = 7'b1000000
   } state_type;

   state_type                        state_ff, state_in;
   logic [RW-1:0]                    clr_row_ff, clr_row_in;
   logic [tsa_pkg::MODE_W-1:0]       mode_ff, mode_in;
   logic [RW:0]                      issue_row_ff, issue_row_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic [RW-1:0]                    rd_row_ff, rd_row_in;
   logic [tsa_pkg::PREV_W-1:0]       prev_ff, prev_in;
   logic [GW-1:0]                    lo_ff, lo_in;
   logic [GW-1:0]                    hi_ff, hi_in;
   logic                             mark_set_ff, mark_set_in;
   logic [RW-1:0]                    mark_row_ff, mark_row_in;
   logic [RW-1:0]                    last_row_ff, last_row_in;
   logic                             status_ff, status_in;
   logic [tsa_pkg::SLOT_W-1:0]       number_ff, number_in;

   // Map memory with a registered read port and one write port.
   logic [W-1:0]                     map_mem [tsa_pkg::ROWS];
   logic [W-1:0]                     rd_data_ff;
   logic [RW-1:0]                    rd_addr;
   logic                             wr_en;
   logic [RW-1:0]                    wr_addr;
   logic [W-1:0]                     wr_data;

   logic [tsa_pkg::ADDR_W-1:0]       table_base;
   tsa_pkg::scan_res_type            scan_res;
   logic [tsa_pkg::PREV_W-1:0]       scan_next_prev;
   logic [W-1:0]                     mark_mask;
   logic [GW-1:0]                    hit_pos;
   logic [RGW-1:0]                   first_row_w;
   logic [RGW-1:0]                   hi_row_w;
   logic                             req_fire;

   tsa_csr u_csr (
      .clock      (clock),
      .reset      (reset),
      .psel       (psel),
      .penable    (penable),
      .pwrite     (pwrite),
      .paddr      (paddr),
      .pwdata     (pwdata),
      .prdata     (prdata),
      .pready     (pready),
      .table_base (table_base)
   );

   tsa_scan_unit u_scan (
      .row_bits  (rd_data_ff),
      .prev_bits (prev_ff),
      .single    (mode_ff == tsa_pkg::MODE_ALLOC_ONE),
      .result    (scan_res),
      .next_prev (scan_next_prev)
   );

   assign req_fire    = req_if.valid && req_if.ready;
   assign hit_pos     = GW'({rd_row_ff, scan_res.pos});
   assign first_row_w = lo_ff[GW-1:tsa_pkg::LOG_W];
   assign hi_row_w    = hi_ff[GW-1:tsa_pkg::LOG_W];

   // Bits of the current row that fall inside the slot range being marked or freed.
   always_comb begin
      for (int j = 0; j < W; j++) begin
         mark_mask[j] = (GW'({mark_row_ff, tsa_pkg::POS_W'(j)}) >= lo_ff) &&
                        (GW'({mark_row_ff, tsa_pkg::POS_W'(j)}) <= hi_ff);
      end
   end

   always_comb begin
      rd_addr = issue_row_ff[RW-1:0];
      if (state_ff == ST_MARK_RD) begin
         rd_addr = mark_row_ff;
      end
   end

   always_comb begin
      wr_en   = 1'b0;
      wr_addr = mark_row_ff;
      wr_data = mark_set_ff ? (rd_data_ff | mark_mask) : (rd_data_ff & ~mark_mask);
      if (state_ff == ST_CLEAR) begin
         wr_en   = 1'b1;
         wr_addr = clr_row_ff;
         wr_data = '0;
      end else if (state_ff == ST_MARK_WR) begin
         wr_en   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= map_mem[rd_addr];
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
   end

   // Sequencer.
   always_comb begin
      state_in     = state_ff;
      clr_row_in   = clr_row_ff;
      mode_in      = mode_ff;
      issue_row_in = issue_row_ff;
      rd_vld_in    = 1'b0;
      rd_row_in    = rd_row_ff;
      prev_in      = prev_ff;
      lo_in        = lo_ff;
      hi_in        = hi_ff;
      mark_set_in  = mark_set_ff;
      mark_row_in  = mark_row_ff;
      last_row_in  = last_row_ff;
      status_in    = status_ff;
      number_in    = number_ff;

      unique case (state_ff)
         ST_CLEAR: begin
            clr_row_in = clr_row_ff + RW'(1);
            if (clr_row_ff == LAST_ROW) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_fire) begin
               mode_in      = req_if.mode;
               status_in    = tsa_pkg::STATUS_DONE;
               issue_row_in = '0;
               prev_in      = '1;
               if (req_if.mode == tsa_pkg::MODE_ALLOC_ONE ||
                   req_if.mode == tsa_pkg::MODE_ALLOC_RUN) begin
                  state_in = ST_SCAN;
               end else begin
                  // Freeing echoes the requested slot and clears its range.
                  number_in   = req_if.slot_index;
                  mark_set_in = 1'b0;
                  lo_in       = GW'(req_if.slot_index);
                  hi_in       = (req_if.mode == tsa_pkg::MODE_FREE_RUN) ?
                                GW'(req_if.slot_index) + RUN_SPAN :
                                GW'(req_if.slot_index);
                  state_in    = ST_SETUP;
               end
            end
         end
         ST_SCAN: begin
            // Reads are issued one row ahead of the row being examined.
            if (issue_row_ff < ROWS_CNT) begin
               rd_vld_in    = 1'b1;
               rd_row_in    = issue_row_ff[RW-1:0];
               issue_row_in = issue_row_ff + (RW + 1)'(1);
            end
            if (rd_vld_ff) begin
               if (scan_res.hit) begin
                  rd_vld_in   = 1'b0;
                  mark_set_in = 1'b1;
                  hi_in       = hit_pos;
                  lo_in       = (mode_ff == tsa_pkg::MODE_ALLOC_RUN) ?
                                hit_pos - RUN_SPAN : hit_pos;
                  state_in    = ST_SETUP;
               end else if (rd_row_ff == LAST_ROW) begin
                  rd_vld_in = 1'b0;
                  status_in = tsa_pkg::STATUS_NO_SPACE;
                  number_in = '0;
                  state_in  = ST_RESP;
               end else begin
                  prev_in = scan_next_prev;
               end
            end
         end
         ST_SETUP: begin
            if (mark_set_ff) begin
               number_in = lo_ff[tsa_pkg::SLOT_W-1:0];
            end
            mark_row_in = first_row_w[RW-1:0];
            last_row_in = (hi_row_w >= ROWS_WIDE) ? LAST_ROW : hi_row_w[RW-1:0];
            // A free that starts beyond the map touches nothing.
            if (first_row_w >= ROWS_WIDE) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_MARK_RD;
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            if (mark_row_ff == last_row_ff) begin
               state_in = ST_RESP;
            end else begin
               mark_row_in = mark_row_ff + RW'(1);
               state_in    = ST_MARK_RD;
            end
         end
         ST_RESP: begin
            if (rsp_if.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_row_ff <= '0;
         rd_vld_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_row_ff <= clr_row_in;
         rd_vld_ff  <= rd_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      issue_row_ff <= issue_row_in;
      rd_row_ff    <= rd_row_in;
      prev_ff      <= prev_in;
      lo_ff        <= lo_in;
      hi_ff        <= hi_in;
      mark_set_ff  <= mark_set_in;
      mark_row_ff  <= mark_row_in;
      last_row_ff  <= last_row_in;
      status_ff    <= status_in;
      number_ff    <= number_in;
   end

   assign req_if.ready        = (state_ff == ST_IDLE);
   assign rsp_if.valid        = (state_ff == ST_RESP);
   assign rsp_if.status       = status_ff;
   assign rsp_if.slot_number  = number_ff;
   assign rsp_if.slot_address = table_base +
                                (tsa_pkg::ADDR_W'(number_ff) << tsa_pkg::SLOT_SHIFT);

endmodule

// ----- rtl/core/tsa_checker.sv -----
// Port-level checker for the table slot allocator and its bind.
module tsa_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic                         rsp_status,
   input logic [tsa_pkg::SLOT_W-1:0]   rsp_slot_number,
   input logic [tsa_pkg::ADDR_W-1:0]   rsp_slot_address
);

   // A response word waiting to be taken keeps its contents.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_slot_number) && $stable(rsp_slot_address))
      else $error("response word changed while stalled");

   // No request word is taken while a response word is pending.
   a_no_req_during_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request ready while response pending");

   // The block works on one request word at a time.
   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request ready right after an accepted word");

   // A no-space result reports slot zero.
   a_no_space_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == tsa_pkg::STATUS_NO_SPACE) |-> rsp_slot_number == '0)
      else $error("no-space response with nonzero slot");

endmodule

bind table_slot_allocator tsa_checker u_tsa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_status       (rsp_if.status),
   .rsp_slot_number  (rsp_if.slot_number),
   .rsp_slot_address (rsp_if.slot_address)
);
